// ----- hw/rtl/mrx_pkg.sv -----
`timescale 1ns / 1ps

package mrx_pkg;

  // target and source opcodes
  localparam logic [3:0] OP_NOP   = 4'h0;
  localparam logic [3:0] OP_ADD   = 4'h1;
  localparam logic [3:0] OP_MUL   = 4'h2;
  localparam logic [3:0] OP_SOU   = 4'h3;
  localparam logic [3:0] OP_DIV   = 4'h4;
  localparam logic [3:0] OP_COP   = 4'h5;
  localparam logic [3:0] OP_AFC   = 4'h6;
  localparam logic [3:0] OP_LOAD  = 4'h7;
  localparam logic [3:0] OP_STORE = 4'h8;

  // error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_ADDRESS  = 3'd1;
  localparam logic [2:0] ERR_CONSTANT = 3'd2;
  localparam logic [2:0] ERR_OPCODE   = 3'd3;
  localparam logic [2:0] ERR_TOO_LONG = 3'd4;

  localparam int COUNT_W = 9;
  localparam int STEP_W = 3;
  localparam int DEF_ADDRESS_LIMIT = 256;
  localparam int DEF_PROGRAM_LIMIT = 256;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // afc constant magnitude bound
  localparam logic signed [15:0] CONST_MAG = 16'sd256;

  typedef struct packed {
    logic [3:0]         func;
    logic [15:0]        first_arg;
    logic signed [15:0] second_arg;
    logic [15:0]        third_arg;
    logic               end_of_program;
  } item_t;

  typedef struct packed {
    logic [3:0] target_op;
    logic [7:0] operand_a;
    logic [7:0] operand_b;
    logic [7:0] operand_c;
    logic       last_of_run;
    logic [2:0] error_code;
  } result_t;

  typedef enum logic [2:0] {
    K_ERR   = 3'd0,
    K_NOP   = 3'd1,
    K_ARITH = 3'd2,
    K_COP   = 3'd3,
    K_AFC   = 3'd4,
    K_LOAD  = 3'd5,
    K_STORE = 3'd6
  } kind_t;

  // classified source instruction, what the back end needs to expand it
  typedef struct packed {
    kind_t      kind;
    logic [3:0] func;
    logic [7:0] a0;
    logic [7:0] b1;
    logic [7:0] a2;
    logic [2:0] err;
  } desc_t;

  typedef struct packed {
    logic  valid;
    desc_t desc;
  } desc_beat_t;

  function automatic logic [STEP_W-1:0] run_length(kind_t k);
    logic [STEP_W-1:0] n;
    case (k)
      K_ARITH: n = 3'd7;
      K_COP:   n = 3'd4;
      K_AFC:   n = 3'd3;
      K_LOAD:  n = 3'd5;
      K_STORE: n = 3'd4;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic result_t make(logic [3:0] op, logic [7:0] a, logic [7:0] b,
                                   logic [7:0] c);
    result_t r;
    r = '0;
    r.target_op = op;
    r.operand_a = a;
    r.operand_b = b;
    r.operand_c = c;
    return r;
  endfunction

  // one target instruction of the run for a descriptor
  function automatic result_t expand(desc_t d, logic [STEP_W-1:0] step);
    result_t r;
    r = '0;
    case (d.kind)
      K_ERR: begin
        r.error_code = d.err;
      end
      K_ARITH: begin
        case (step)
          3'd0: r = make(OP_AFC, 8'd1, d.b1, 8'd0);
          3'd1: r = make(OP_AFC, 8'd2, d.a2, 8'd0);
          3'd2: r = make(OP_LOAD, 8'd1, 8'd1, 8'd0);
          3'd3: r = make(OP_LOAD, 8'd2, 8'd2, 8'd0);
          3'd4: r = make(OP_AFC, 8'd3, d.a0, 8'd0);
          3'd5: r = make(d.func, 8'd0, 8'd1, 8'd2);
          default: r = make(OP_STORE, 8'd3, 8'd0, 8'd0);
        endcase
      end
      K_COP: begin
        case (step)
          3'd0: r = make(OP_AFC, 8'd0, d.a0, 8'd0);
          3'd1: r = make(OP_AFC, 8'd1, d.b1, 8'd0);
          3'd2: r = make(OP_LOAD, 8'd0, 8'd0, 8'd0);
          default: r = make(OP_STORE, 8'd1, 8'd0, 8'd0);
        endcase
      end
      K_AFC: begin
        case (step)
          3'd0: r = make(OP_AFC, 8'd0, d.a0, 8'd0);
          3'd1: r = make(OP_AFC, 8'd1, d.b1, 8'd0);
          default: r = make(OP_STORE, 8'd0, 8'd1, 8'd0);
        endcase
      end
      K_LOAD: begin
        case (step)
          3'd0: r = make(OP_AFC, 8'd1, d.b1, 8'd0);
          3'd1: r = make(OP_AFC, 8'd0, d.a0, 8'd0);
          3'd2: r = make(OP_LOAD, 8'd1, 8'd1, 8'd0);
          3'd3: r = make(OP_LOAD, 8'd1, 8'd1, 8'd0);
          default: r = make(OP_STORE, 8'd0, 8'd1, 8'd0);
        endcase
      end
      K_STORE: begin
        case (step)
          3'd0: r = make(OP_AFC, 8'd1, d.a0, 8'd0);
          3'd1: r = make(OP_AFC, 8'd0, d.b1, 8'd0);
          3'd2: r = make(OP_LOAD, 8'd1, 8'd1, 8'd0);
          default: r = make(OP_STORE, 8'd1, 8'd0, 8'd0);
        endcase
      end
      default: r = make(OP_NOP, 8'd0, 8'd0, 8'd0);
    endcase
    r.last_of_run = (step == run_length(d.kind) - 3'd1);
    return r;
  endfunction

endpackage

// ----- hw/rtl/mrx_front.sv -----
`timescale 1ns / 1ps

module mrx_front import mrx_pkg::*; #(
  parameter int ADDRESS_LIMIT = DEF_ADDRESS_LIMIT,
  parameter int PROGRAM_LIMIT = DEF_PROGRAM_LIMIT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  item_t      item,
  output desc_beat_t beat
);

  logic [COUNT_W-1:0] emitted_count;
  logic [COUNT_W-1:0] emitted_count_next;
  logic               halted;
  logic               halted_next;

  logic  bad0, bad1, bad2, bad_const, too_long, bad_op;
  desc_t d;

  always_comb begin
    bad0      = item.first_arg >= 16'(ADDRESS_LIMIT);
    bad1      = item.second_arg[15] || (16'(item.second_arg) >= 16'(ADDRESS_LIMIT));
    bad2      = item.third_arg >= 16'(ADDRESS_LIMIT);
    bad_const = (item.second_arg > CONST_MAG) || (item.second_arg < -CONST_MAG);
    too_long  = emitted_count > COUNT_W'(PROGRAM_LIMIT);
    bad_op    = (item.func == OP_DIV) || (item.func > OP_STORE);

    d.func = item.func;
    d.a0   = item.first_arg[7:0];
    d.b1   = item.second_arg[7:0];
    d.a2   = item.third_arg[7:0];
    d.err  = ERR_NONE;
    d.kind = K_ERR;

    if (too_long) begin
      d.err = ERR_TOO_LONG;
    end else if (bad_op) begin
      d.err = ERR_OPCODE;
    end else if (item.func == OP_NOP) begin
      d.kind = K_NOP;
    end else if (item.func <= OP_SOU) begin
      if (bad0 || bad1 || bad2) d.err = ERR_ADDRESS;
      else d.kind = K_ARITH;
    end else if (item.func == OP_COP) begin
      if (bad0 || bad1) d.err = ERR_ADDRESS;
      else d.kind = K_COP;
    end else if (item.func == OP_AFC) begin
      if (bad0) d.err = ERR_ADDRESS;
      else if (bad_const) d.err = ERR_CONSTANT;
      else d.kind = K_AFC;
    end else if (item.func == OP_LOAD) begin
      if (bad0 || bad1) d.err = ERR_ADDRESS;
      else d.kind = K_LOAD;
    end else begin
      if (bad0 || bad1) d.err = ERR_ADDRESS;
      else d.kind = K_STORE;
    end

    emitted_count_next = emitted_count;
    halted_next        = halted;
    if (!halted) begin
      if (d.kind == K_ERR) begin
        halted_next = 1'b1;
      end else begin
        emitted_count_next = emitted_count + COUNT_W'(run_length(d.kind));
      end
    end
    if (item.end_of_program) begin
      emitted_count_next = '0;
      halted_next        = 1'b0;
    end

    // a halted source instruction gives nothing to the back end
    beat.valid = accept && !halted;
    beat.desc  = d;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emitted_count <= '0;
      halted        <= 1'b0;
    end else if (accept) begin
      emitted_count <= emitted_count_next;
      halted        <= halted_next;
    end
  end

endmodule

// ----- hw/rtl/mrx_queue.sv -----
`timescale 1ns / 1ps

module mrx_queue import mrx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  desc_beat_t wr,
  input  logic       rd,
  output logic       full,
  output desc_beat_t head
);

  desc_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QPTR_W:0]    count;
  logic               do_wr;
  logic               do_rd;

  assign full       = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign head.valid = count != '0;
  assign head.desc  = entries[rd_ptr];
  assign do_wr      = wr.valid && !full;
  assign do_rd      = rd && head.valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr.desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hw/rtl/mrx_back.sv -----
`timescale 1ns / 1ps

module mrx_back import mrx_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  desc_beat_t head,
  output logic       rd,
  input  logic       pop,
  output logic       empty,
  output result_t    result
);

  logic [STEP_W-1:0] step;
  logic              out_valid;
  result_t           next_res;
  logic              load;

  assign empty    = !out_valid;
  assign next_res = expand(head.desc, step);
  assign load     = head.valid && (!out_valid || pop);
  assign rd       = load && next_res.last_of_run;

  always_ff @(posedge clk) begin
    if (load) begin
      result <= next_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        step      <= next_res.last_of_run ? '0 : step + 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/mem_to_reg_instruction_expander.sv -----
`timescale 1ns / 1ps

// Expands memory-to-memory source instructions into register-machine
// instructions. The front end takes one source instruction per cycle while
// its four-entry descriptor queue has room, checks it (program length,
// opcode, addresses, afc constant) and keeps the emitted count and halt
// flag; the back end expands the queue head one target instruction per
// cycle into an output register while that register is empty or popped. A
// source instruction gives 7 results for add/mul/sou, 5 for load, 4 for
// cop/store, 3 for afc and 1 for nop or an error beat, set by the back-end
// sequencer; instructions swallowed while halted give nothing at the back.
// Results leave like a queue: the oldest waiting one sits on result while
// empty is low.

module mem_to_reg_instruction_expander import mrx_pkg::*; #(
  parameter int ADDRESS_LIMIT = DEF_ADDRESS_LIMIT,
  parameter int PROGRAM_LIMIT = DEF_PROGRAM_LIMIT
) (
  input  logic    clk,
  input  logic    rst,
  // source instruction side
  input  logic    push,
  output logic    full,
  input  item_t   item,
  // target instruction side
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  desc_beat_t fe_beat;   // classified beat from the front end
  desc_beat_t q_head;    // oldest descriptor waiting for expansion
  logic       q_rd;
  logic       accept;

  // an accepted beat is classified and, unless the front end is halted, enqueued in the same cycle
  assign accept = push && !full;

  mrx_front #(
    .ADDRESS_LIMIT(ADDRESS_LIMIT),
    .PROGRAM_LIMIT(PROGRAM_LIMIT)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .item  (item),
    .beat  (fe_beat)
  );

  // decouples classification from expansion
  mrx_queue u_queue (
    .clk (clk),
    .rst (rst),
    .wr  (fe_beat),
    .rd  (q_rd),
    .full(full),
    .head(q_head)
  );

  // one target instruction per cycle while the output is empty or popped, registered at the output
  mrx_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (q_head),
    .rd    (q_rd),
    .pop   (pop),
    .empty (empty),
    .result(result)
  );

endmodule

// ----- test/target_stream_checker.sv -----
`timescale 1ns / 1ps

module target_stream_checker import mrx_pkg::*; #(
  parameter int ADDRESS_LIMIT = DEF_ADDRESS_LIMIT,
  parameter int PROGRAM_LIMIT = DEF_PROGRAM_LIMIT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  logic    full,
  input  item_t   item,
  input  logic    empty,
  input  logic    pop,
  input  result_t result,
  output int      pending,
  output int      mismatches
);

  result_t            expected_targets[$];
  result_t            want;
  logic [COUNT_W-1:0] emitted_count;
  logic               halted;
  int                 beat_index;

  task automatic report_mismatch(input string what);
    $display("%0t ns: target beat %0d: %s", $time, beat_index, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, exp_val));
    end
  endtask

  function automatic result_t target_beat(logic [3:0] op, logic [7:0] a,
                                          logic [7:0] b, logic [7:0] c);
    result_t r;
    r = '0;
    r.target_op = op;
    r.operand_a = a;
    r.operand_b = b;
    r.operand_c = c;
    return r;
  endfunction

  task automatic predict_expansion(input item_t src);
    result_t    run[7];
    int         n;
    int         arg1;
    logic       bad0;
    logic       bad1;
    logic       bad2;
    logic [7:0] a0;
    logic [7:0] b1;
    logic [7:0] a2;
    logic [2:0] fault;
    arg1 = int'($signed(src.second_arg));
    bad0 = src.first_arg >= ADDRESS_LIMIT;
    bad1 = arg1 < 0 || arg1 >= ADDRESS_LIMIT;
    bad2 = src.third_arg >= ADDRESS_LIMIT;
    a0 = src.first_arg[7:0];
    b1 = src.second_arg[7:0];
    a2 = src.third_arg[7:0];
    n = 0;
    fault = ERR_NONE;
    if (halted) begin
      n = 0;
    end else if (emitted_count > PROGRAM_LIMIT) begin
      fault = ERR_TOO_LONG;
    end else if (src.func == OP_DIV || src.func > OP_STORE) begin
      fault = ERR_OPCODE;
    end else begin
      case (src.func)
        OP_NOP: begin
          run[0] = target_beat(OP_NOP, 8'd0, 8'd0, 8'd0);
          n = 1;
        end
        OP_ADD, OP_MUL, OP_SOU: begin
          if (bad0 || bad1 || bad2) begin
            fault = ERR_ADDRESS;
          end else begin
            run[0] = target_beat(OP_AFC, 8'd1, b1, 8'd0);
            run[1] = target_beat(OP_AFC, 8'd2, a2, 8'd0);
            run[2] = target_beat(OP_LOAD, 8'd1, 8'd1, 8'd0);
            run[3] = target_beat(OP_LOAD, 8'd2, 8'd2, 8'd0);
            run[4] = target_beat(OP_AFC, 8'd3, a0, 8'd0);
            run[5] = target_beat(src.func, 8'd0, 8'd1, 8'd2);
            run[6] = target_beat(OP_STORE, 8'd3, 8'd0, 8'd0);
            n = 7;
          end
        end
        OP_COP: begin
          if (bad0 || bad1) begin
            fault = ERR_ADDRESS;
          end else begin
            run[0] = target_beat(OP_AFC, 8'd0, a0, 8'd0);
            run[1] = target_beat(OP_AFC, 8'd1, b1, 8'd0);
            run[2] = target_beat(OP_LOAD, 8'd0, 8'd0, 8'd0);
            run[3] = target_beat(OP_STORE, 8'd1, 8'd0, 8'd0);
            n = 4;
          end
        end
        OP_AFC: begin
          if (bad0) begin
            fault = ERR_ADDRESS;
          end else if (arg1 > int'(CONST_MAG) || arg1 < -int'(CONST_MAG)) begin
            fault = ERR_CONSTANT;
          end else begin
            run[0] = target_beat(OP_AFC, 8'd0, a0, 8'd0);
            run[1] = target_beat(OP_AFC, 8'd1, b1, 8'd0);
            run[2] = target_beat(OP_STORE, 8'd0, 8'd1, 8'd0);
            n = 3;
          end
        end
        OP_LOAD: begin
          if (bad0 || bad1) begin
            fault = ERR_ADDRESS;
          end else begin
            run[0] = target_beat(OP_AFC, 8'd1, b1, 8'd0);
            run[1] = target_beat(OP_AFC, 8'd0, a0, 8'd0);
            run[2] = target_beat(OP_LOAD, 8'd1, 8'd1, 8'd0);
            run[3] = target_beat(OP_LOAD, 8'd1, 8'd1, 8'd0);
            run[4] = target_beat(OP_STORE, 8'd0, 8'd1, 8'd0);
            n = 5;
          end
        end
        default: begin
          if (bad0 || bad1) begin
            fault = ERR_ADDRESS;
          end else begin
            run[0] = target_beat(OP_AFC, 8'd1, a0, 8'd0);
            run[1] = target_beat(OP_AFC, 8'd0, b1, 8'd0);
            run[2] = target_beat(OP_LOAD, 8'd1, 8'd1, 8'd0);
            run[3] = target_beat(OP_STORE, 8'd1, 8'd0, 8'd0);
            n = 4;
          end
        end
      endcase
    end
    // an error beat halts and leaves the count alone
    if (fault != ERR_NONE) begin
      run[0] = target_beat(OP_NOP, 8'd0, 8'd0, 8'd0);
      run[0].last_of_run = 1'b1;
      run[0].error_code = fault;
      n = 1;
      halted = 1'b1;
    end else if (n > 0) begin
      run[n-1].last_of_run = 1'b1;
      emitted_count = emitted_count + COUNT_W'(n);
    end
    if (src.end_of_program) begin
      emitted_count = '0;
      halted = 1'b0;
    end
    for (int k = 0; k < n; k++) begin
      expected_targets.push_back(run[k]);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_targets.delete();
      emitted_count = '0;
      halted = 1'b0;
      beat_index = 0;
      mismatches = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_targets.size() == 0) begin
          report_mismatch("target beat with nothing expected");
        end else begin
          want = expected_targets.pop_front();
          check_field("target_op", 8'(result.target_op), 8'(want.target_op));
          check_field("operand_a", result.operand_a, want.operand_a);
          check_field("operand_b", result.operand_b, want.operand_b);
          check_field("operand_c", result.operand_c, want.operand_c);
          check_field("last_of_run", 8'(result.last_of_run), 8'(want.last_of_run));
          check_field("error_code", 8'(result.error_code), 8'(want.error_code));
        end
        beat_index++;
      end
      if (push && !full) begin
        predict_expansion(item);
      end
    end
    pending <= expected_targets.size();
  end

endmodule

// ----- test/tb_mem_to_reg_instruction_expander.sv -----
`timescale 1ns / 1ps

module tb_mem_to_reg_instruction_expander;
  import mrx_pkg::*;

  // unsupported opcodes beyond store
  localparam logic [3:0] OP_PAST_STORE = 4'h9;
  localparam logic [3:0] OP_TOP_CODE   = 4'hF;

  // length of a program that runs into the program limit: 36 arithmetic
  // instructions and one copy land exactly on the limit, the next one
  // still expands, the one after that is refused as too long
  localparam int LIMIT_RUN = 41;

  localparam int ITEM_TARGET = 460;
  localparam int CALM_FROM   = 400;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  item_t   item;
  logic    empty;
  logic    pop;
  result_t result;
  int      pending;
  int      mismatches;
  int      sent;
  logic    calm;

  mem_to_reg_instruction_expander i_dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  // prediction and comparison live in the checker, it only hands back counts
  target_stream_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item       (item),
    .empty      (empty),
    .pop        (pop),
    .result     (result),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #3_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: pops most cycles, stalls now and then until calm is set
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
      pop <= 1'b1;
    end
  end

  function automatic item_t source_item(logic [3:0] f, int a, int b, int c, logic eop);
    item_t s;
    s.func = f;
    s.first_arg = a[15:0];
    s.second_arg = b[15:0];
    s.third_arg = c[15:0];
    s.end_of_program = eop;
    return s;
  endfunction

  function automatic logic [3:0] supported_func();
    logic [3:0] f;
    case ($urandom_range(0, 7))
      0: f = OP_NOP;
      1: f = OP_ADD;
      2: f = OP_MUL;
      3: f = OP_SOU;
      4: f = OP_COP;
      5: f = OP_AFC;
      6: f = OP_LOAD;
      default: f = OP_STORE;
    endcase
    return f;
  endfunction

  // legal instruction with random content; fields the op ignores stay random
  function automatic item_t wellformed_item(logic [3:0] f, logic eop);
    item_t s;
    s = source_item(f, $urandom, $urandom, $urandom, eop);
    if (f != OP_NOP) begin
      s.first_arg = 16'($urandom_range(0, 255));
      if (f == OP_AFC) begin
        s.second_arg = 16'(int'($urandom_range(0, 512)) - 256);
      end else begin
        s.second_arg = 16'($urandom_range(0, 255));
      end
      if (f == OP_ADD || f == OP_MUL || f == OP_SOU) begin
        s.third_arg = 16'($urandom_range(0, 255));
      end
    end
    return s;
  endfunction

  // broken instructions: pure noise or one argument out of bounds
  function automatic item_t broken_item(logic eop);
    item_t s;
    s = wellformed_item(supported_func(), eop);
    case ($urandom_range(0, 3))
      0: s = source_item(4'($urandom_range(0, 15)), $urandom, $urandom, $urandom,
                         1'($urandom_range(0, 1)));
      1: s.first_arg = 16'($urandom_range(256, 65535));
      2: s.second_arg = 16'(-int'($urandom_range(1, 32768)));
      default: begin
        s.func = OP_AFC;
        s.second_arg = $urandom_range(0, 1) ? 16'(int'($urandom_range(257, 400)))
                                            : 16'(-int'($urandom_range(257, 400)));
      end
    endcase
    return s;
  endfunction

  // one beat on the input; push stays high so back-to-back beats need no gap
  task automatic send_source(input item_t src);
    @(negedge clk);
    item <= src;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sent++;
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
    end
  endtask

  task automatic drain_targets();
    @(negedge clk);
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_program(input int length);
    item_t s;
    for (int k = 0; k < length; k++) begin
      if ($urandom_range(0, 99) < 85) begin
        s = wellformed_item(supported_func(), k == length - 1);
      end else begin
        s = broken_item(k == length - 1);
      end
      send_source(s);
      sender_gap();
    end
  endtask

  task automatic send_limit_program();
    logic [3:0] f;
    for (int k = 0; k < LIMIT_RUN; k++) begin
      f = (k == 36) ? OP_COP : OP_ADD + 4'($urandom_range(0, 2));
      send_source(wellformed_item(f, k == LIMIT_RUN - 1));
      sender_gap();
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    calm = 1'b0;
    sent = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: every op, several at the edges of their arguments
    send_source(source_item(OP_NOP, 16'hFFFF, -1, 16'hFFFF, 1'b0));
    send_source(source_item(OP_ADD, 255, 255, 255, 1'b0));
    send_source(source_item(OP_MUL, 0, 0, 0, 1'b0));
    send_source(source_item(OP_SOU, 17, 200, 3, 1'b0));
    send_source(source_item(OP_COP, 255, 0, 16'hFFFF, 1'b0));
    // afc constants at both ends of the allowed range
    send_source(source_item(OP_AFC, 0, 256, 0, 1'b0));
    send_source(source_item(OP_AFC, 255, -256, 0, 1'b0));
    send_source(source_item(OP_AFC, 10, -1, 0, 1'b0));
    send_source(source_item(OP_LOAD, 128, 127, 16'hFFFF, 1'b0));
    send_source(source_item(OP_STORE, 1, 254, 0, 1'b1));
    // address fault halts, the next beat is swallowed, end of program clears
    send_source(source_item(OP_ADD, 256, 1, 1, 1'b0));
    send_source(source_item(OP_ADD, 1, 1, 1, 1'b0));
    send_source(source_item(OP_NOP, 0, 0, 0, 1'b1));
    // constant just out of range on both sides
    send_source(source_item(OP_AFC, 3, 257, 0, 1'b1));
    send_source(source_item(OP_AFC, 3, -257, 0, 1'b1));
    // unsupported opcodes
    send_source(source_item(OP_DIV, 0, 0, 0, 1'b1));
    send_source(source_item(OP_PAST_STORE, 0, 0, 0, 1'b1));
    send_source(source_item(OP_TOP_CODE, 0, 0, 0, 1'b1));
    // each address argument out of bounds, negative source too
    send_source(source_item(OP_AFC, 16'hFFFF, 0, 0, 1'b1));
    send_source(source_item(OP_STORE, 0, -32768, 0, 1'b1));
    send_source(source_item(OP_COP, 0, 256, 0, 1'b1));
    send_source(source_item(OP_MUL, 0, 0, 256, 1'b1));
    send_source(source_item(OP_SOU, 0, 16'h7FFF, 0, 1'b1));

    // hold off until the directed beats have all come back
    drain_targets();
    send_limit_program();

    // random programs; now and then one that overruns the program limit
    for (int prog = 0; sent < ITEM_TARGET; prog++) begin
      calm = (sent >= CALM_FROM);
      if ($urandom_range(0, 11) == 0) begin
        send_limit_program();
      end else begin
        send_program($urandom_range(1, 12));
      end
      if (prog % 10 == 9) begin
        drain_targets();
      end
    end

    drain_targets();
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
